@@ design/lbrs_pkg.sv @@
// shared constants and types of the bit-packed lcg random source
`default_nettype none

package lbrs_pkg;

   // generator modulus width and rejection retry limit
   localparam int MOD_BITS  = 31;
   localparam int TRI_TRIES = 64;
   localparam int TRY_W     = $clog2(TRI_TRIES);

   // register and field widths
   localparam int MULT_W     = 31;
   localparam int INCR_W     = 31;
   localparam int SEED_W     = 31;
   localparam int SIZE_W     = 2;
   localparam int UNIT_W     = 32;
   localparam int PROD_W     = 2 * UNIT_W;
   localparam int PACK_W     = 64;
   localparam int CNT_W      = 6;
   localparam int BYTES_W    = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 8;

   localparam logic [MULT_W-1:0] MULT_RESET = MULT_W'(1103515245);
   localparam logic [INCR_W-1:0] INCR_RESET = INCR_W'(12345);

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_MULTIPLIER = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INCREMENT  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEED       = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNIT_SIZE  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_RANGE_MIN  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_RANGE_MAX  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_TRIANGULAR = 3'd6;

   // unit size codes, anything else means long
   localparam logic [SIZE_W-1:0] SIZE_BYTE  = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_WORD  = 2'd1;
   localparam logic [SIZE_W-1:0] SIZE_LONG  = 2'd2;
   localparam logic [SIZE_W-1:0] SIZE_SPARE = 2'd3;  // unused code, taken as long

   typedef struct packed {
      logic [MULT_W-1:0] multiplier;
      logic [INCR_W-1:0] increment;
      logic [SIZE_W-1:0] unit_size;
      logic              triangular;
   } cfg_type;

   typedef struct packed {
      logic              scale_en;
      logic [UNIT_W-1:0] lo;
      logic [UNIT_W-1:0] scale;
      logic [UNIT_W-1:0] mid;
      logic [UNIT_W-1:0] span;
   } range_type;

   typedef struct packed {
      logic              load;
      logic [SEED_W-1:0] value;
   } seed_type;

   typedef struct packed {
      logic draw_start;
      logic lcg_add;
      logic pack;
      logic unit_load;
      logic take;
   } bits_cmd_type;

   typedef struct packed {
      logic need_zero;
      logic left_zero;
      logic cnt_full;
   } bits_stat_type;

endpackage

`default_nettype wire

@@ design/lbrs_mul.sv @@
// shared 32x32 multiplier with registered product
`default_nettype none

module lbrs_mul import lbrs_pkg::*; (
   input  logic              clock,
   input  logic [UNIT_W-1:0] op_a,
   input  logic [UNIT_W-1:0] op_b,
   output logic [PROD_W-1:0] prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
   end

endmodule

`default_nettype wire

@@ design/lbrs_cfg.sv @@
// configuration registers and registered range setup
`default_nettype none

module lbrs_cfg import lbrs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg,
   output range_type             rng,
   output seed_type              seed
);

   logic [MULT_W-1:0] multiplier_ff, multiplier_in;
   logic [INCR_W-1:0] increment_ff, increment_in;
   logic [SIZE_W-1:0] unit_size_ff, unit_size_in;
   logic [UNIT_W-1:0] range_min_ff, range_min_in;
   logic [UNIT_W-1:0] range_max_ff, range_max_in;
   logic              triangular_ff, triangular_in;

   // first setup stage
   logic [UNIT_W-1:0] umask, hi_clamp;
   logic              en_s1;
   logic [UNIT_W-1:0] lo1_ff, lo1_in, hi1_ff, hi1_in;
   logic              en1_ff, inc1_ff, inc1_in;

   // second setup stage
   logic [UNIT_W:0]   sum2;
   logic [UNIT_W-1:0] diff2;
   range_type         rng_ff, rng_in;

   always_comb begin
      multiplier_in = multiplier_ff;
      increment_in  = increment_ff;
      unit_size_in  = unit_size_ff;
      range_min_in  = range_min_ff;
      range_max_in  = range_max_ff;
      triangular_in = triangular_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_MULTIPLIER: multiplier_in = csr_wdata[MULT_W-1:0];
            CSR_INCREMENT:  increment_in  = csr_wdata[INCR_W-1:0];
            CSR_UNIT_SIZE:  unit_size_in  = csr_wdata[SIZE_W-1:0];
            CSR_RANGE_MIN:  range_min_in  = csr_wdata[UNIT_W-1:0];
            CSR_RANGE_MAX:  range_max_in  = csr_wdata[UNIT_W-1:0];
            CSR_TRIANGULAR: triangular_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         multiplier_ff <= MULT_RESET;
         increment_ff  <= INCR_RESET;
         unit_size_ff  <= SIZE_BYTE;
         range_min_ff  <= '0;
         range_max_ff  <= '0;
         triangular_ff <= 1'b0;
      end else begin
         multiplier_ff <= multiplier_in;
         increment_ff  <= increment_in;
         unit_size_ff  <= unit_size_in;
         range_min_ff  <= range_min_in;
         range_max_ff  <= range_max_in;
         triangular_ff <= triangular_in;
      end
   end

   // clamp max to the unit mask, fall back to the full unit range
   always_comb begin
      case (unit_size_ff)
         SIZE_BYTE: umask = UNIT_W'(8'hff);
         SIZE_WORD: umask = UNIT_W'(16'hffff);
         default:   umask = '1;
      endcase
      hi_clamp = (range_max_ff > umask) ? umask : range_max_ff;
      en_s1    = (hi_clamp != '0) && (range_min_ff < hi_clamp);
      lo1_in   = en_s1 ? range_min_ff : '0;
      hi1_in   = en_s1 ? hi_clamp : umask;
      inc1_in  = (range_min_ff != '0) || (hi_clamp != '1);
   end

   // scale = hi - lo (+1 unless the range is the whole 32-bit space)
   always_comb begin
      sum2            = {1'b0, lo1_ff} + {1'b0, hi1_ff};
      diff2           = hi1_ff - lo1_ff;
      rng_in.scale_en = en1_ff;
      rng_in.lo       = lo1_ff;
      rng_in.scale    = hi1_ff - lo1_ff + UNIT_W'(inc1_ff);
      rng_in.mid      = sum2[UNIT_W:1];
      rng_in.span     = {1'b0, diff2[UNIT_W-1:1]};
   end

   always_ff @(posedge clock) begin
      lo1_ff  <= lo1_in;
      hi1_ff  <= hi1_in;
      en1_ff  <= en_s1;
      inc1_ff <= inc1_in;
      rng_ff  <= rng_in;
   end

   assign cfg.multiplier = multiplier_ff;
   assign cfg.increment  = increment_ff;
   assign cfg.unit_size  = unit_size_ff;
   assign cfg.triangular = triangular_ff;
   assign rng            = rng_ff;
   assign seed.load      = csr_we && (csr_addr == CSR_SEED);
   assign seed.value     = csr_wdata[SEED_W-1:0];

endmodule

`default_nettype wire

@@ design/lbrs_bits.sv @@
// generator state, pack buffer and unit word with byte-grain extraction
`default_nettype none

module lbrs_bits import lbrs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  seed_type            seed,
   input  bits_cmd_type        cmd,
   input  logic [PROD_W-1:0]   prod,
   output bits_stat_type       stat,
   output logic [MOD_BITS-1:0] gen,
   output logic [UNIT_W-1:0]   acc
);

   logic [MOD_BITS-1:0] gen_ff, gen_in;
   logic [PACK_W-1:0]   pack_buf_ff, pack_buf_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [UNIT_W-1:0]   unit_ff, unit_in;
   logic [BYTES_W-1:0]  left_ff, left_in;
   logic [BYTES_W-1:0]  need_ff, need_in;
   logic [UNIT_W-1:0]   acc_ff, acc_in;
   logic [BYTES_W-1:0]  take_n;

   // a long that straddles with one byte left takes a word then a byte
   always_comb begin
      if ((need_ff == BYTES_W'(3)) && (left_ff == BYTES_W'(4)))
         take_n = BYTES_W'(2);
      else if (need_ff < left_ff)
         take_n = need_ff;
      else
         take_n = left_ff;
   end

   always_comb begin
      gen_in      = gen_ff;
      pack_buf_in = pack_buf_ff;
      cnt_in      = cnt_ff;
      unit_in     = unit_ff;
      left_in     = left_ff;
      need_in     = need_ff;
      acc_in      = acc_ff;
      if (seed.load) begin
         gen_in      = MOD_BITS'(seed.value);
         pack_buf_in = '0;
         cnt_in      = '0;
         unit_in     = '0;
         left_in     = '0;
      end else begin
         if (cmd.draw_start) begin
            acc_in = '0;
            case (cfg.unit_size)
               SIZE_BYTE: need_in = BYTES_W'(1);
               SIZE_WORD: need_in = BYTES_W'(2);
               default:   need_in = BYTES_W'(4);
            endcase
         end
         if (cmd.lcg_add)
            gen_in = prod[MOD_BITS-1:0] + MOD_BITS'(cfg.increment);
         if (cmd.pack) begin
            if (cnt_ff == '0)
               pack_buf_in = PACK_W'(gen_ff);
            else
               pack_buf_in = pack_buf_ff | (PACK_W'(gen_ff) << cnt_ff);
            cnt_in = cnt_ff + CNT_W'(MOD_BITS);
         end
         if (cmd.unit_load) begin
            unit_in     = pack_buf_ff[UNIT_W-1:0];
            pack_buf_in = pack_buf_ff >> UNIT_W;
            cnt_in      = cnt_ff - CNT_W'(UNIT_W);
            left_in     = BYTES_W'(4);
         end
         if (cmd.take) begin
            case (take_n)
               BYTES_W'(1): begin
                  acc_in  = {acc_ff[23:0], unit_ff[7:0]};
                  unit_in = {8'd0, unit_ff[31:8]};
               end
               BYTES_W'(2): begin
                  acc_in  = {acc_ff[15:0], unit_ff[15:0]};
                  unit_in = {16'd0, unit_ff[31:16]};
               end
               BYTES_W'(3): begin
                  acc_in  = {acc_ff[7:0], unit_ff[23:0]};
                  unit_in = {24'd0, unit_ff[31:24]};
               end
               BYTES_W'(4): begin
                  acc_in  = unit_ff;
                  unit_in = '0;
               end
               default: ;
            endcase
            left_in = left_ff - take_n;
            need_in = need_ff - take_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff      <= '0;
         pack_buf_ff <= '0;
         cnt_ff      <= '0;
         unit_ff     <= '0;
         left_ff     <= '0;
         need_ff     <= '0;
      end else begin
         gen_ff      <= gen_in;
         pack_buf_ff <= pack_buf_in;
         cnt_ff      <= cnt_in;
         unit_ff     <= unit_in;
         left_ff     <= left_in;
         need_ff     <= need_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign stat.need_zero = (need_ff == '0);
   assign stat.left_zero = (left_ff == '0);
   assign stat.cnt_full  = (cnt_ff >= CNT_W'(UNIT_W));
   assign gen            = gen_ff;
   assign acc            = acc_ff;

endmodule

`default_nettype wire

@@ design/lcg_bitpacked_random_source_top.sv @@
// top level of the bit-packed lcg random source: sequencer around one shared multiplier
//
// req channel: one word per request, req_tdata[0] = 1 asks for a random unit,
//   a word with bit 0 clear is taken and dropped without a result
// rsp channel: one 32-bit word per request, the unit zero-extended
// csr port: csr_we with csr_addr selects multiplier, increment, seed, unit_size,
//   range_min, range_max or triangular; a seed write restarts the generator
//   and empties both bit buffers
// the sequencer works on one request at a time; req_tready is high only when idle
// from accept the sequencer starts a draw, extracts the unit in 1 to 3 pieces,
//   scales it with a multiply and an add when scaling, then loads the output
//   slot; every new 32-bit unit word is cut from the pack buffer after 1 or 2
//   generator steps, each a step check, the lcg multiply, the add and the pack
// triangular mode repeats a candidate and a test draw (the test draw ends in a
//   multiply and a check) until accepted, at most 64 pairs; the multiplier is
//   the shared unit that bounds all of this
// reset restores the default multiplier and increment, a zero generator value
//   and empty buffers; the first request may follow reset at once
// a stalled rsp holds its word; the block may take and work on the next
//   request meanwhile but waits before the output slot until it frees up
`default_nettype none

module lcg_bitpacked_random_source_top import lbrs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request side
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [0] request, [7:1] zero
   // result side
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [UNIT_W-1:0]     rsp_tdata,  // [31:0] value
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_START     = 11'b000_0000_0010,
      ST_DRAW      = 11'b000_0000_0100,
      ST_LCG_MUL   = 11'b000_0000_1000,
      ST_LCG_ADD   = 11'b000_0001_0000,
      ST_PACK      = 11'b000_0010_0000,
      ST_SCALE_MUL = 11'b000_0100_0000,
      ST_SCALE_ADD = 11'b000_1000_0000,
      ST_TEST_MUL  = 11'b001_0000_0000,
      ST_TEST_CHK  = 11'b010_0000_0000,
      ST_FINISH    = 11'b100_0000_0000
   } state_type;

   cfg_type             cfg;
   range_type           rng;
   seed_type            seed;
   bits_cmd_type        cmd;
   bits_stat_type       stat;
   logic [MOD_BITS-1:0] gen;
   logic [UNIT_W-1:0]   acc;
   logic [UNIT_W-1:0]   mul_a, mul_b;
   logic [PROD_W-1:0]   prod;

   state_type         state_ff, state_in;
   logic              phase_ff, phase_in;   // 0 candidate draw, 1 test draw
   logic [TRY_W-1:0]  tries_ff, tries_in;
   logic [UNIT_W-1:0] v_ff, v_in;
   logic [UNIT_W-1:0] chk_ff, chk_in;
   logic              chk_big_ff, chk_big_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [UNIT_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic [UNIT_W-1:0] prod_shr, prod_sum;
   logic [UNIT_W:0]   mid2;
   logic              accept;

   lbrs_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .rng       (rng),
      .seed      (seed)
   );

   lbrs_bits u_bits (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .seed  (seed),
      .cmd   (cmd),
      .prod  (prod),
      .stat  (stat),
      .gen   (gen),
      .acc   (acc)
   );

   lbrs_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   // product shifted down by the unit width, then offset by the range low end
   always_comb begin
      case (cfg.unit_size)
         SIZE_BYTE: prod_shr = prod[39:8];
         SIZE_WORD: prod_shr = prod[47:16];
         default:   prod_shr = prod[63:32];
      endcase
      prod_sum = prod_shr + rng.lo;
   end

   // check value: candidate mirrored about mid; below zero wraps huge and always wins
   always_comb begin
      mid2       = {rng.mid, 1'b0};
      chk_big_in = ({1'b0, v_ff} > mid2);
      if (v_ff > rng.mid)
         chk_in = mid2[UNIT_W-1:0] - v_ff;
      else
         chk_in = v_ff;
      accept = chk_big_ff || (chk_ff > prod_sum);
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_LCG_MUL: begin
            mul_a = UNIT_W'(gen);
            mul_b = UNIT_W'(cfg.multiplier);
         end
         ST_SCALE_MUL: begin
            mul_a = acc;
            mul_b = rng.scale;
         end
         ST_TEST_MUL: begin
            mul_a = acc;
            mul_b = rng.span;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      tries_in      = tries_ff;
      v_in          = v_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tdata[0]) begin
               phase_in = 1'b0;
               tries_in = '0;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.draw_start = 1'b1;
            state_in       = ST_DRAW;
         end
         ST_DRAW: begin
            if (stat.need_zero) begin
               if (phase_ff) begin
                  state_in = ST_TEST_MUL;
               end else if (rng.scale_en) begin
                  state_in = ST_SCALE_MUL;
               end else begin
                  v_in = acc;
                  if (cfg.triangular) begin
                     phase_in = 1'b1;
                     state_in = ST_START;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            end else if (stat.left_zero) begin
               // refill: step the generator until a full unit word is packed
               if (stat.cnt_full)
                  cmd.unit_load = 1'b1;
               else
                  state_in = ST_LCG_MUL;
            end else begin
               cmd.take = 1'b1;
            end
         end
         ST_LCG_MUL: state_in = ST_LCG_ADD;
         ST_LCG_ADD: begin
            cmd.lcg_add = 1'b1;
            state_in    = ST_PACK;
         end
         ST_PACK: begin
            cmd.pack = 1'b1;
            state_in = ST_DRAW;
         end
         ST_SCALE_MUL: state_in = ST_SCALE_ADD;
         ST_SCALE_ADD: begin
            v_in = prod_sum;
            if (cfg.triangular) begin
               phase_in = 1'b1;
               state_in = ST_START;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_TEST_MUL: state_in = ST_TEST_CHK;
         ST_TEST_CHK: begin
            if (accept || (tries_ff == TRY_W'(TRI_TRIES - 1))) begin
               state_in = ST_FINISH;
            end else begin
               tries_in = tries_ff + TRY_W'(1);
               phase_in = 1'b0;
               state_in = ST_START;
            end
         end
         ST_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = v_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= 1'b0;
         tries_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         tries_ff      <= tries_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff         <= v_in;
      chk_ff       <= chk_in;
      chk_big_ff   <= chk_big_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

@@ tb/random_unit_checker.sv @@
// checker for the bit-packed lcg random source: tracks registers, predicts units, compares
module random_unit_checker import lbrs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [UNIT_W-1:0]     rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           pending,
   output int unsigned           errors
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] GEN_MASK = (64'd1 << MOD_BITS) - 64'd1;

   // register copies
   logic [63:0]       mult_r, incr_r, min_r, max_r;
   logic [SIZE_W-1:0] size_r;
   logic              tri_r;

   // generator and the two bit buffers
   logic [63:0]       gen_r, pack_r;
   int unsigned       pack_cnt;
   logic [31:0]       word_r;
   int unsigned       word_left;

   logic [UNIT_W-1:0] expected_units[$];
   logic [UNIT_W-1:0] want;

   function automatic void clear_buffers();
      pack_r    = '0;
      pack_cnt  = 0;
      word_r    = '0;
      word_left = 0;
   endfunction

   // step the generator until a full 32-bit word can be cut from the pack buffer
   function automatic void refill_word();
      while (pack_cnt < 32) begin
         gen_r = (gen_r * mult_r + incr_r) & GEN_MASK;
         if (pack_cnt > 0)
            pack_r = pack_r | (gen_r << pack_cnt);
         else
            pack_r = gen_r;
         pack_cnt += MOD_BITS;
      end
      word_r    = pack_r[31:0];
      pack_r    = pack_r >> 32;
      pack_cnt -= 32;
      word_left = 32;
   endfunction

   function automatic logic [31:0] pull_byte();
      logic [31:0] r;
      if (word_left == 0)
         refill_word();
      r         = word_r & 32'hff;
      word_r    = word_r >> 8;
      word_left = (word_left >= 8) ? word_left - 8 : 0;
      return r;
   endfunction

   function automatic logic [31:0] pull_half();
      logic [31:0] r;
      if (word_left == 0)
         refill_word();
      if (word_left >= 16) begin
         r          = word_r & 32'hffff;
         word_r     = word_r >> 16;
         word_left -= 16;
      end else begin
         // leftover byte becomes the high byte
         r         = (word_r & 32'hff) << 8;
         word_left = 0;
         r         = r | pull_byte();
      end
      return r & 32'hffff;
   endfunction

   function automatic logic [31:0] pull_full();
      logic [31:0] r;
      if (word_left == 0)
         refill_word();
      if (word_left >= 32) begin
         r         = word_r;
         word_r    = '0;
         word_left = 0;
      end else if (word_left == 24) begin
         r         = (word_r & 32'hffffff) << 8;
         word_left = 0;
         r         = r | pull_byte();
      end else if (word_left == 16) begin
         r         = (word_r & 32'hffff) << 16;
         word_left = 0;
         r         = r | pull_half();
      end else begin
         r         = (word_r & 32'hff) << 16;
         word_left = 0;
         r         = r | pull_half();
         r         = (r << 8) | pull_byte();
      end
      return r;
   endfunction

   function automatic logic [63:0] draw_unit();
      if (size_r == SIZE_BYTE)
         return {32'd0, pull_byte()};
      if (size_r == SIZE_WORD)
         return {32'd0, pull_half()};
      return {32'd0, pull_full()};
   endfunction

   // one requested unit: draw, scale into the range, triangular rejection
   function automatic logic [UNIT_W-1:0] predict_unit();
      int unsigned bits;
      int          n;
      logic        done;
      logic [63:0] umask, lo, hi, scale, mid, v, t, c;
      bits  = (size_r == SIZE_BYTE) ? 8 : (size_r == SIZE_WORD) ? 16 : 32;
      umask = (64'd1 << bits) - 64'd1;
      lo    = min_r;
      hi    = (max_r > umask) ? umask : max_r;
      if (hi > 0 && lo < hi) begin
         scale = hi - lo;
         if (lo > 0 || hi != 64'hffff_ffff)
            scale = scale + 1;
      end else begin
         scale = '0;
         lo    = '0;
         hi    = umask;
      end
      mid  = (lo + hi) / 2;
      v    = '0;
      done = 1'b0;
      for (n = 0; n < TRI_TRIES && !done; n++) begin
         v = draw_unit();
         if (scale != 0)
            v = ((v * scale) >> bits) + lo;
         if (!tri_r) begin
            done = 1'b1;
         end else begin
            t = draw_unit();
            t = ((t * (mid - lo)) >> bits) + lo;
            c = (v > mid) ? mid * 2 - v : v;
            done = (c > t);
         end
      end
      return v[UNIT_W-1:0];
   endfunction

   function automatic void write_reg(input logic [CSR_ADDR_W-1:0] a,
                                     input logic [CSR_DATA_W-1:0] d);
      case (a)
         CSR_MULTIPLIER: mult_r = {33'd0, d[30:0]};
         CSR_INCREMENT:  incr_r = {33'd0, d[30:0]};
         CSR_SEED: begin
            gen_r = {33'd0, d[30:0]};
            clear_buffers();
         end
         CSR_UNIT_SIZE:  size_r = d[SIZE_W-1:0];
         CSR_RANGE_MIN:  min_r  = {32'd0, d};
         CSR_RANGE_MAX:  max_r  = {32'd0, d};
         CSR_TRIANGULAR: tri_r  = d[0];
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         mult_r = {33'd0, MULT_RESET};
         incr_r = {33'd0, INCR_RESET};
         size_r = SIZE_BYTE;
         min_r  = '0;
         max_r  = '0;
         tri_r  = 1'b0;
         gen_r  = '0;
         clear_buffers();
         expected_units.delete();
         pending <= 0;
         errors  <= 0;
      end else begin
         if (csr_we)
            write_reg(csr_addr, csr_wdata);
         // results first: a result never belongs to a request taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_units.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %h", $time, rsp_tdata);
               errors <= errors + 1;
            end else begin
               want = expected_units.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t: value mismatch, expected %h actual %h",
                           $time, want, rsp_tdata);
                  errors <= errors + 1;
               end
            end
         end
         if (req_tvalid && req_tready && req_tdata[0])
            expected_units.push_back(predict_unit());
         pending <= expected_units.size();
      end
   end

endmodule

@@ tb/lcg_bitpacked_random_source_top_test.sv @@
// testbench top for the bit-packed lcg random source: stimulus, register setups and verdict
module lcg_bitpacked_random_source_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lbrs_pkg::*;

   // request words that ask for a unit (zero words are extra and not counted)
   localparam int ITEM_TARGET   = 1800;
   // cycles allowed after the last result before touching registers or ending,
   // covers a dropped zero word still in flight
   localparam int SETTLE_CYCLES = 40;
   // long receiver hold-off that backs the block up into its request side
   localparam int LONG_HOLD     = 300;

   typedef struct {
      logic [MULT_W-1:0] mult;
      logic [INCR_W-1:0] incr;
      logic [SEED_W-1:0] seed;
      logic              reseed;
      logic [SIZE_W-1:0] size;
      logic [UNIT_W-1:0] lo_lim;
      logic [UNIT_W-1:0] hi_lim;
      logic              tri_on;
   } gen_setup_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [UNIT_W-1:0]     rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int unsigned           open_units;
   int unsigned           fail_count;

   // idling knobs, in percent of cycles
   int                    idle_pct     = 0;
   int                    stall_pct    = 0;
   logic                  hold_request = 1'b0;

   lcg_bitpacked_random_source_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   random_unit_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .pending    (open_units),
      .errors     (fail_count)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs; sized for every request running the
   // full set of rejection retries with the receiver stalling on each word
   initial begin
      #200_000_000;
      $display("lcg_bitpacked_random_source_top_test NOT OK");
      $finish;
   end

   // receiver: random stalls per cycle, or one long hold-off when asked for
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // one register write; csr_we is lowered by the caller after the last one
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] a, input logic [CSR_DATA_W-1:0] d);
      csr_we    <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= d;
      @(posedge clock);
   endtask

   // write all registers of a setup; the seed only when a restart is wanted,
   // so that bits left over in the buffers carry across size changes
   task automatic apply_setup(input gen_setup_type s);
      write_reg(CSR_MULTIPLIER, {1'b0, s.mult});
      write_reg(CSR_INCREMENT, {1'b0, s.incr});
      if (s.reseed)
         write_reg(CSR_SEED, {1'b0, s.seed});
      write_reg(CSR_UNIT_SIZE, {30'd0, s.size});
      write_reg(CSR_RANGE_MIN, s.lo_lim);
      write_reg(CSR_RANGE_MAX, s.hi_lim);
      write_reg(CSR_TRIANGULAR, {31'd0, s.tri_on});
      csr_we <= 1'b0;
   endtask

   // offer one request word, with random idle cycles ahead of it;
   // ready is looked at mid-cycle, the word is taken at the next rising edge
   task automatic offer(input logic want_unit);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(want_unit);
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   // stop offering, wait for every expected word, then let the block go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (open_units != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic gen_setup_type setup_of(input logic [30:0] mult,
                                              input logic [30:0] incr,
                                              input logic [30:0] seed, input logic reseed,
                                              input logic [1:0] size, input logic [31:0] lo_lim,
                                              input logic [31:0] hi_lim, input logic tri_on);
      gen_setup_type s;
      s.mult   = mult;
      s.incr   = incr;
      s.seed   = seed;
      s.reseed = reseed;
      s.size   = size;
      s.lo_lim = lo_lim;
      s.hi_lim = hi_lim;
      s.tri_on = tri_on;
      return s;
   endfunction

   task automatic directed(input gen_setup_type s, input int count);
      settle();
      apply_setup(s);
      repeat (count) offer(1'b1);
   endtask

   // random setup: default and extreme generator constants, every unit size
   // code, and ranges that scale, clamp, collapse or switch scaling off
   function automatic gen_setup_type rand_setup();
      gen_setup_type s;
      case ($urandom_range(3))
         0: s.mult = MULT_RESET;
         1: s.mult = 31'($urandom);
         2: s.mult = '1;
         default: s.mult = 31'($urandom_range(15));
      endcase
      case ($urandom_range(3))
         0: s.incr = INCR_RESET;
         1: s.incr = 31'($urandom);
         2: s.incr = '1;
         default: s.incr = '0;
      endcase
      case ($urandom_range(3))
         0: s.seed = '0;
         1: s.seed = '1;
         default: s.seed = 31'($urandom);
      endcase
      s.reseed = 1'($urandom_range(1));
      s.size   = SIZE_W'($urandom_range(3));
      case ($urandom_range(5))
         0: begin
            // scaling off
            s.lo_lim = '0;
            s.hi_lim = '0;
         end
         1: begin
            s.lo_lim = $urandom;
            s.hi_lim = $urandom;
         end
         2: begin
            // narrow ranges near zero, which can overrun a byte
            s.lo_lim = $urandom_range(200);
            s.hi_lim = s.lo_lim + $urandom_range(1, 300);
         end
         3: begin
            s.lo_lim = $urandom_range(16'hffff);
            s.hi_lim = s.lo_lim + $urandom_range(1, 16'hffff);
         end
         4: begin
            // whole 32-bit range, the odd scale case for longs
            s.lo_lim = '0;
            s.hi_lim = '1;
         end
         default: begin
            // empty range: min equal to max
            s.lo_lim = $urandom;
            s.hi_lim = s.lo_lim;
         end
      endcase
      s.tri_on = ($urandom_range(3) == 0);
      return s;
   endfunction

   initial begin
      int            sent;
      int            phase;
      int            len;
      logic          want_unit;
      gen_setup_type s;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: byte units, no scaling; a zero word gives no result
      offer(1'b1);
      offer(1'b0);
      offer(1'b1);
      offer(1'b1);

      // all-zero generator constants and seed
      directed(setup_of('0, '0, '0, 1'b1, SIZE_BYTE, '0, '0, 1'b0), 1);

      // all-ones constants, then size changes without restart so units straddle
      // leftover bits: byte, word, long from a byte left, word from a byte left,
      // and unit size three taken as long
      directed(setup_of('1, '1, '1, 1'b1, SIZE_BYTE, '0, '0, 1'b0), 1);
      directed(setup_of('1, '1, '1, 1'b0, SIZE_WORD, '0, '0, 1'b0), 1);
      directed(setup_of('1, '1, '1, 1'b0, SIZE_LONG, '0, '0, 1'b0), 1);
      directed(setup_of('1, '1, '1, 1'b0, SIZE_WORD, '0, '0, 1'b0), 1);
      directed(setup_of('1, '1, '1, 1'b0, SIZE_SPARE, '0, '0, 1'b0), 1);

      // long from a fresh word, full 32-bit range
      directed(setup_of(MULT_RESET, INCR_RESET, 31'd7, 1'b1, SIZE_LONG, '0, '1, 1'b0), 2);

      // max above the byte mask gets clamped
      directed(setup_of(MULT_RESET, INCR_RESET, 31'd7, 1'b0, SIZE_BYTE, 32'd10,
                        32'h1000, 1'b0), 2);

      // min above max: returned unscaled
      directed(setup_of(MULT_RESET, INCR_RESET, 31'd7, 1'b0, SIZE_WORD, 32'd500,
                        32'd100, 1'b0), 1);

      // triangular over the whole byte range
      directed(setup_of(MULT_RESET, INCR_RESET, 31'd7, 1'b0, SIZE_BYTE, '0, '0, 1'b1), 2);

      // two-value range: every pair gets rejected, last candidate comes out
      directed(setup_of(MULT_RESET, INCR_RESET, 31'd7, 1'b0, SIZE_WORD, 32'd100,
                        32'd101, 1'b1), 1);

      // triangular over the upper half of the long range
      directed(setup_of(MULT_RESET, INCR_RESET, 31'd7, 1'b0, SIZE_LONG, 32'h8000_0000,
                        '1, 1'b1), 2);

      // random phases, idling pattern rotating per phase
      sent  = 0;
      phase = 0;
      while (sent < ITEM_TARGET) begin
         settle();
         s = rand_setup();
         apply_setup(s);
         case (phase % 5)
            1: begin
               idle_pct  = 59;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 59;
            end
            3: begin
               idle_pct  = 25;
               stall_pct = 25;
            end
            default: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
         endcase
         // once, early: receiver stops for a long while as the sender keeps going
         if (phase == 0)
            hold_request = 1'b1;
         len = $urandom_range(30, 110);
         repeat (len) begin
            want_unit = ($urandom_range(99) >= 8);
            offer(want_unit);
            if (want_unit)
               sent++;
         end
         phase++;
      end

      settle();
      if (fail_count == 0)
         $display("lcg_bitpacked_random_source_top_test OK");
      else
         $display("lcg_bitpacked_random_source_top_test NOT OK");
      $finish;
   end

endmodule

@@ sim.f @@
design/lbrs_pkg.sv
design/lbrs_mul.sv
design/lbrs_cfg.sv
design/lbrs_bits.sv
design/lcg_bitpacked_random_source_top.sv
tb/random_unit_checker.sv
tb/lcg_bitpacked_random_source_top_test.sv
